### design/mwm_pkg.sv
// Shared types and constants for the maze wall map.
package mwm_pkg;

    localparam int CMD_W         = 2;
    localparam int COORD_W       = 6;
    localparam int XW            = COORD_W + 2;
    localparam int DIR_W         = 2;
    localparam int MASK_W        = 4;
    localparam int NUM_WALLS     = 3;
    localparam int GRID_SIZE_DEF = 16;

    // Wall sides, also bit positions in a cell mask
    localparam logic [DIR_W-1:0] SIDE_N = 2'd0;
    localparam logic [DIR_W-1:0] SIDE_E = 2'd1;
    localparam logic [DIR_W-1:0] SIDE_S = 2'd2;
    localparam logic [DIR_W-1:0] SIDE_W = 2'd3;

    // Heading offsets: opposite, left and right side
    localparam logic [DIR_W-1:0] TURN_BACK  = 2'd2;
    localparam logic [DIR_W-1:0] TURN_LEFT  = 2'd3;
    localparam logic [DIR_W-1:0] TURN_RIGHT = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_SENSE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

endpackage

### design/maze_wall_map.sv
// Wall map of a square maze: one 4-bit wall mask per cell, kept in a memory.
//
// Usage: one command is taken on the input channel (in_valid/in_ready) and
// exactly one result comes back on the output channel (out_valid/out_ready).
// Commands: init map, write wall, check wall, sensor update. The block works on
// one command at a time; in_ready is high only while it is idle.
// Every in-grid cell touched costs one read-modify-write on the single memory
// port. The addressed cell is updated once with all of its walls, then each
// in-grid neighbour in turn: check wall touches only the cell, write wall up
// to one neighbour, sensor update up to three; commands on cells outside the
// grid touch no cell. Init map sweeps every cell once, and reset starts the
// same sweep, which loads the boundary walls; no command is taken until it
// finishes.
// The result sits in an output register; the next command is taken while it
// waits, and a finished command holds until that register is free.
module maze_wall_map #(
    parameter int GRID_SIZE = mwm_pkg::GRID_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mwm_pkg::CMD_W-1:0]         command,
    input  logic signed [mwm_pkg::COORD_W-1:0] x_coord,
    input  logic signed [mwm_pkg::COORD_W-1:0] y_coord,
    input  logic [mwm_pkg::DIR_W-1:0]         direction,
    input  logic                              wall_value,
    input  logic                              front_wall,
    input  logic                              left_wall,
    input  logic                              right_wall,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              wall_present,
    output logic [mwm_pkg::MASK_W-1:0]        cell_walls
);
    import mwm_pkg::*;

    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_SIZE);

    function automatic logic grid_hit(input logic signed [XW-1:0] cx,
                                      input logic signed [XW-1:0] cy);
        return !cx[XW-1] && !cy[XW-1] &&
               ($unsigned(cx) < XW'(GRID_SIZE)) && ($unsigned(cy) < XW'(GRID_SIZE));
    endfunction

    function automatic logic [MASK_W-1:0] boundary_walls(input logic [CW-1:0] cx,
                                                         input logic [CW-1:0] cy);
        logic [MASK_W-1:0] m;
        m         = '0;
        m[SIDE_N] = (cy == CW'(GRID_SIZE - 1));
        m[SIDE_S] = (cy == '0);
        m[SIDE_W] = (cx == '0);
        m[SIDE_E] = (cx == CW'(GRID_SIZE - 1));
        return m;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy);
        return AW'(AW'(cy) * AW'(GRID_SIZE) + AW'(cx));
    endfunction

    state_t state_reg, state_next;

    cmd_t                     cmd_reg;
    logic signed [XW-1:0]     x_reg, y_reg;
    logic [DIR_W-1:0]         side_reg [NUM_WALLS];
    logic [NUM_WALLS-1:0]     val_reg;
    logic [1:0]               nwall_reg;
    logic [1:0]               step_reg, step_next;
    logic                     item_reg;
    logic [CW-1:0]            clr_x_reg, clr_y_reg;
    logic [MASK_W-1:0]        walls_reg;
    logic                     present_reg;
    logic [MASK_W-1:0]        rd_data_reg;
    logic                     out_valid_reg;
    logic                     wall_present_reg;
    logic [MASK_W-1:0]        cell_walls_reg;

    logic [MASK_W-1:0]        mem [DEPTH];

    // Control outputs of the sequencer
    logic                     accept;
    logic                     rd_en;
    logic                     mem_we;
    logic                     load_out;

    // Datapath
    logic signed [XW-1:0]     in_x, in_y;
    logic                     in_hit;
    logic [1:0]               widx;
    logic [DIR_W-1:0]         nb_side;
    logic [DIR_W-1:0]         nb_opp;
    logic signed [XW-1:0]     tgt_x, tgt_y;
    logic                     tgt_hit;
    logic [AW-1:0]            tgt_addr;
    logic [AW-1:0]            clr_addr;
    logic                     clr_last;
    logic                     last_step;
    logic [MASK_W-1:0]        set_mask, clr_mask;
    logic [MASK_W-1:0]        new_walls;
    logic [AW-1:0]            mem_waddr;
    logic [MASK_W-1:0]        mem_wdata;

    assign in_x    = XW'(x_coord);
    assign in_y    = XW'(y_coord);
    assign in_hit  = grid_hit(in_x, in_y);

    assign widx    = (step_reg == 2'd0) ? 2'd0 : step_reg - 2'd1;
    assign nb_side = side_reg[widx];
    assign nb_opp  = nb_side + TURN_BACK;

    // Step zero targets the cell itself, later steps the neighbor behind each wall
    always_comb
    begin
        tgt_x = x_reg;
        tgt_y = y_reg;
        if (step_reg != 2'd0)
        begin
            unique case (nb_side)
                SIDE_N:  tgt_y = y_reg + XW'(1);
                SIDE_E:  tgt_x = x_reg + XW'(1);
                SIDE_S:  tgt_y = y_reg - XW'(1);
                SIDE_W:  tgt_x = x_reg - XW'(1);
                default: tgt_x = x_reg;
            endcase
        end
    end

    assign tgt_hit   = grid_hit(tgt_x, tgt_y);
    assign tgt_addr  = cell_addr(tgt_x[CW-1:0], tgt_y[CW-1:0]);
    assign clr_addr  = cell_addr(clr_x_reg, clr_y_reg);
    assign clr_last  = (clr_x_reg == CW'(GRID_SIZE - 1)) && (clr_y_reg == CW'(GRID_SIZE - 1));
    assign last_step = (step_reg == nwall_reg);

    always_comb
    begin
        set_mask = '0;
        clr_mask = '0;
        for (int j = 0; j < NUM_WALLS; j++)
        begin
            if (2'(j) < nwall_reg)
            begin
                set_mask[side_reg[j]] = val_reg[j];
                clr_mask[side_reg[j]] = !val_reg[j];
            end
        end
    end

    always_comb
    begin
        if (step_reg == 2'd0)
            new_walls = (rd_data_reg & ~clr_mask) | set_mask;
        else if (val_reg[widx])
            new_walls = rd_data_reg | (MASK_W'(1) << nb_opp);
        else
            new_walls = rd_data_reg & ~(MASK_W'(1) << nb_opp);
    end

    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr : tgt_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? boundary_walls(clr_x_reg, clr_y_reg)
                                               : new_walls;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = item_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                step_next = 2'd0;
                if (in_valid)
                begin
                    if (cmd_t'(command) == CMD_INIT)
                        state_next = ST_CLEAR;
                    else
                        state_next = in_hit ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                if (tgt_hit)
                    state_next = ST_MODIFY;
                else if (last_step)
                    state_next = ST_DONE;
                else
                    step_next = step_reg + 2'd1;
            end
            ST_MODIFY:
            begin
                if (last_step)
                    state_next = ST_DONE;
                else
                begin
                    state_next = ST_READ;
                    step_next  = step_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        mem_we   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  mem_we   = 1'b1;
            ST_IDLE:   in_ready = 1'b1;
            ST_READ:   rd_en    = tgt_hit;
            ST_MODIFY: mem_we   = 1'b1;
            ST_DONE:   load_out = !out_valid_reg || out_ready;
            default:   in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[tgt_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= 2'd0;
            item_reg      <= 1'b0;
            clr_x_reg     <= '0;
            clr_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (accept)
                item_reg <= 1'b1;
            else if (load_out)
                item_reg <= 1'b0;
            // Sweep column by column within a row, wrap to zero at the end
            if (state_reg == ST_CLEAR)
            begin
                if (clr_x_reg == CW'(GRID_SIZE - 1))
                begin
                    clr_x_reg <= '0;
                    clr_y_reg <= (clr_y_reg == CW'(GRID_SIZE - 1)) ? '0 : clr_y_reg + CW'(1);
                end
                else
                    clr_x_reg <= clr_x_reg + CW'(1);
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_t'(command);
            x_reg       <= in_x;
            y_reg       <= in_y;
            side_reg[0] <= direction;
            side_reg[1] <= direction + TURN_LEFT;
            side_reg[2] <= direction + TURN_RIGHT;
            val_reg     <= {right_wall, left_wall,
                            (cmd_t'(command) == CMD_WRITE) ? wall_value : front_wall};
            unique case (cmd_t'(command))
                CMD_WRITE: nwall_reg <= 2'd1;
                CMD_SENSE: nwall_reg <= 2'd3;
                default:   nwall_reg <= 2'd0;
            endcase
            present_reg <= (cmd_t'(command) == CMD_CHECK) && !in_hit;
            if (in_hit && (cmd_t'(command) == CMD_INIT))
                walls_reg <= boundary_walls(in_x[CW-1:0], in_y[CW-1:0]);
            else
                walls_reg <= '0;
        end
        else if ((state_reg == ST_MODIFY) && (step_reg == 2'd0))
        begin
            // Capture the cell after its own update; neighbors never alias it
            walls_reg   <= new_walls;
            present_reg <= (cmd_reg == CMD_CHECK) && rd_data_reg[side_reg[0]];
        end
        if (load_out)
        begin
            wall_present_reg <= present_reg;
            cell_walls_reg   <= walls_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign wall_present = wall_present_reg;
    assign cell_walls   = cell_walls_reg;

`ifndef SYNTHESIS
    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !item_reg)
        else $error("command taken while another is in flight");

    a_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> item_reg)
        else $error("result loaded with no command in flight");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY) |-> (step_reg <= nwall_reg))
        else $error("update step beyond the walls of the command");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("finished command dropped while output stalled");
`endif

endmodule

### dv/tb.sv
// Self-checking testbench for the maze wall map: directed and random commands against a shadow wall map.
`timescale 1ns / 100ps

module tb;

    import mwm_pkg::*;

    localparam int GRID        = GRID_SIZE_DEF;
    localparam int RANDOM_CMDS = 1680;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIR_W-1:0]          dir;
        logic                      wv;
        logic                      fw;
        logic                      lw;
        logic                      rw;
    } wall_cmd_t;

    typedef struct packed {
        logic              present;
        logic [MASK_W-1:0] walls;
    } wall_report_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          command    = '0;
    logic signed [COORD_W-1:0] x_coord    = '0;
    logic signed [COORD_W-1:0] y_coord    = '0;
    logic [DIR_W-1:0]          direction  = '0;
    logic                      wall_value = 1'b0;
    logic                      front_wall = 1'b0;
    logic                      left_wall  = 1'b0;
    logic                      right_wall = 1'b0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic                      wall_present;
    logic [MASK_W-1:0]         cell_walls;

    wall_cmd_t    pending_cmds[$];
    wall_report_t wall_reports[$];
    logic [MASK_W-1:0] shadow_walls [0:GRID*GRID-1];

    wall_cmd_t next_cmd;
    int total_cmds;
    int cmds_issued;
    int results_seen;
    int mismatches;
    int unexpected;
    int cycle_count;
    int n_init, n_write, n_check, n_sense;

    maze_wall_map #(
        .GRID_SIZE (GRID)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .direction    (direction),
        .wall_value   (wall_value),
        .front_wall   (front_wall),
        .left_wall    (left_wall),
        .right_wall   (right_wall),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .wall_present (wall_present),
        .cell_walls   (cell_walls)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- shadow wall map ----------------

    function automatic bit on_grid(int x, int y);
        return x >= 0 && x < GRID && y >= 0 && y < GRID;
    endfunction

    function automatic void set_side(int x, int y, logic [DIR_W-1:0] side, logic v);
        if (on_grid(x, y))
            shadow_walls[y*GRID + x][side] = v;
    endfunction

    // Set or clear a wall and the matching wall of the neighbor across it.
    function automatic void place_wall(int x, int y, logic [DIR_W-1:0] side, logic v);
        int nx;
        int ny;
        logic [DIR_W-1:0] back;
        nx = x;
        ny = y;
        if (!on_grid(x, y))
            return;
        set_side(x, y, side, v);
        case (side)
            SIDE_N: ny = y + 1;
            SIDE_E: nx = x + 1;
            SIDE_S: ny = y - 1;
            default: nx = x - 1;
        endcase
        back = side + TURN_BACK;
        set_side(nx, ny, back, v);
    endfunction

    function automatic void clear_to_boundary();
        for (int i = 0; i < GRID*GRID; i++)
            shadow_walls[i] = '0;
        for (int i = 0; i < GRID; i++)
        begin
            set_side(i, GRID-1, SIDE_N, 1'b1);
            set_side(i, 0, SIDE_S, 1'b1);
            set_side(0, i, SIDE_W, 1'b1);
            set_side(GRID-1, i, SIDE_E, 1'b1);
        end
    endfunction

    function automatic wall_report_t apply_wall_cmd(wall_cmd_t c);
        wall_report_t rep;
        int x;
        int y;
        logic [DIR_W-1:0] lside;
        logic [DIR_W-1:0] rside;
        x = int'(c.x);
        y = int'(c.y);
        lside = c.dir + TURN_LEFT;
        rside = c.dir + TURN_RIGHT;
        rep.present = 1'b0;
        rep.walls = '0;
        case (c.cmd)
            CMD_INIT:  clear_to_boundary();
            CMD_WRITE: place_wall(x, y, c.dir, c.wv);
            CMD_CHECK: rep.present = on_grid(x, y) ? shadow_walls[y*GRID + x][c.dir] : 1'b1;
            default:
            begin
                place_wall(x, y, c.dir, c.fw);
                place_wall(x, y, lside, c.lw);
                place_wall(x, y, rside, c.rw);
            end
        endcase
        if (on_grid(x, y))
            rep.walls = shadow_walls[y*GRID + x];
        return rep;
    endfunction

    // ---------------- stimulus ----------------

    function automatic wall_cmd_t mk_cmd(cmd_t cmd, int x, int y, logic [DIR_W-1:0] dir,
                                         logic wv, logic fw, logic lw, logic rw);
        wall_cmd_t c;
        c.cmd = cmd;
        c.x = x[COORD_W-1:0];
        c.y = y[COORD_W-1:0];
        c.dir = dir;
        c.wv = wv;
        c.fw = fw;
        c.lw = lw;
        c.rw = rw;
        return c;
    endfunction

    // Mostly in-grid, biased toward the border, sometimes just outside or anywhere.
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, GRID-1);
        if (r < 80)
            return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2)
                                               : $urandom_range(GRID-3, GRID-1);
        if (r < 92)
            return ($urandom_range(0, 1) != 0) ? -1 : GRID;
        return int'($signed(6'($urandom_range(0, 63))));
    endfunction

    function automatic void add_cmd(wall_cmd_t c);
        pending_cmds.push_back(c);
        case (c.cmd)
            CMD_INIT:  n_init++;
            CMD_WRITE: n_write++;
            CMD_CHECK: n_check++;
            default:   n_sense++;
        endcase
    endfunction

    function automatic int send_idle_pct();
        case (cmds_issued * 3 / total_cmds)
            0: return 19;
            1: return 64;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (results_seen * 3 / total_cmds)
            0: return 64;
            1: return 19;
            default: return 0;
        endcase
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= '0;
            x_coord    <= '0;
            y_coord    <= '0;
            direction  <= '0;
            wall_value <= 1'b0;
            front_wall <= 1'b0;
            left_wall  <= 1'b0;
            right_wall <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct())
            begin
                next_cmd = pending_cmds.pop_front();
                cmds_issued++;
                in_valid   <= 1'b1;
                command    <= next_cmd.cmd;
                x_coord    <= next_cmd.x;
                y_coord    <= next_cmd.y;
                direction  <= next_cmd.dir;
                wall_value <= next_cmd.wv;
                front_wall <= next_cmd.fw;
                left_wall  <= next_cmd.lw;
                right_wall <= next_cmd.rw;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                wall_report_t exp_rep;
                results_seen++;
                if (wall_reports.size() == 0)
                begin
                    unexpected++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("ERROR: result with nothing expected: present=%0b walls=%h",
                                 wall_present, cell_walls);
                end
                else
                begin
                    exp_rep = wall_reports.pop_front();
                    if (wall_present !== exp_rep.present || cell_walls !== exp_rep.walls)
                    begin
                        mismatches++;
                        if (mismatches + unexpected <= MAX_REPORTS)
                            $display({"ERROR: result %0d: present exp %0b got %0b, ",
                                      "walls exp %h got %h"},
                                     results_seen, exp_rep.present, wall_present,
                                     exp_rep.walls, cell_walls);
                    end
                end
            end
            // Predict after checking so an early result cannot match its own command.
            if (in_valid && in_ready)
                wall_reports.push_back(apply_wall_cmd(mk_cmd(cmd_t'(command),
                                       int'(x_coord), int'(y_coord), direction,
                                       wall_value, front_wall, left_wall, right_wall)));
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, wall_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        clear_to_boundary();
        total_cmds = 1;

        // Border walls and out-of-grid reads
        add_cmd(mk_cmd(CMD_CHECK, 0, 0, SIDE_S, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, 0, 0, SIDE_W, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, GRID-1, GRID-1, SIDE_N, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, GRID-1, GRID-1, SIDE_E, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, -1, 5, SIDE_N, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, GRID, 5, SIDE_E, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, 5, -1, SIDE_S, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, 5, GRID, SIDE_W, 0, 0, 0, 0));
        // Shared interior wall, boundary wall clear, ignored writes
        add_cmd(mk_cmd(CMD_WRITE, 5, 5, SIDE_E, 1, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, 6, 5, SIDE_W, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_WRITE, GRID-1, GRID-1, SIDE_N, 0, 1, 1, 1));
        add_cmd(mk_cmd(CMD_CHECK, GRID-1, GRID-1, SIDE_N, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_WRITE, 0, 7, SIDE_W, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_WRITE, -1, 7, SIDE_E, 1, 0, 0, 0));
        add_cmd(mk_cmd(CMD_WRITE, 31, -32, SIDE_S, 1, 1, 1, 1));
        add_cmd(mk_cmd(CMD_CHECK, -32, 31, SIDE_W, 1, 1, 1, 1));
        // Sensor updates on every heading, corners and outside
        add_cmd(mk_cmd(CMD_SENSE, 0, 0, SIDE_N, 0, 1, 1, 1));
        add_cmd(mk_cmd(CMD_SENSE, GRID-1, 0, SIDE_E, 0, 1, 0, 1));
        add_cmd(mk_cmd(CMD_SENSE, 7, 8, SIDE_S, 0, 0, 1, 0));
        add_cmd(mk_cmd(CMD_SENSE, 8, 7, SIDE_W, 0, 1, 1, 0));
        add_cmd(mk_cmd(CMD_SENSE, GRID, GRID, SIDE_N, 1, 1, 1, 1));
        // Init restores the border; coordinates only pick the reported cell
        add_cmd(mk_cmd(CMD_INIT, 3, 0, SIDE_N, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_CHECK, 5, 5, SIDE_E, 0, 0, 0, 0));
        add_cmd(mk_cmd(CMD_INIT, -1, 20, SIDE_W, 1, 1, 1, 1));
        add_cmd(mk_cmd(CMD_CHECK, 0, 7, SIDE_W, 0, 0, 0, 0));

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            int r;
            cmd_t c;
            r = $urandom_range(0, 99);
            if (r < 1)
                c = CMD_INIT;
            else if (r < 36)
                c = CMD_WRITE;
            else if (r < 70)
                c = CMD_CHECK;
            else
                c = CMD_SENSE;
            add_cmd(mk_cmd(c, rand_coord(), rand_coord(), DIR_W'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        total_cmds = pending_cmds.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || in_valid || wall_reports.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d inits, %0d wall writes, %0d checks, %0d sensor updates",
                 total_cmds, n_init, n_write, n_check, n_sense);
        $display({"Compared %0d results under three flow-control mixes: ",
                  "%0d mismatches, %0d unexpected"},
                 results_seen, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && wall_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
